// ===== rtl/bcdt_pkg.sv =====
// Package for the BCD countdown timer: state and result types, register map,
// and the BCD step and seven-segment helper functions. No dependencies.
`default_nettype none

package bcdt_pkg;

  localparam int unsigned NumDigits  = 4;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned SegW       = 7;
  localparam int unsigned PrescW     = 8;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  // Register map: word index taken from paddr[2]
  localparam logic REG_TICKS_PER_COUNT = 1'b0;
  localparam logic [PrescW-1:0] TicksPerCountRst = 8'd50;

  localparam logic [DigitW-1:0] DigitMax = 4'd9;

  // Index 0 is units, index 3 is thousands
  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  typedef struct packed {
    logic              running;
    logic [PrescW-1:0] prescale;
    digits_t           digits;
  } timer_state_t;

  typedef struct packed {
    logic [SegW-1:0] seg_thousands;
    logic [SegW-1:0] seg_hundreds;
    logic [SegW-1:0] seg_tens;
    logic [SegW-1:0] seg_units;
    logic            buzzer_on;
    logic            is_running;
  } timer_result_t;

  // Step the value down by one, holding at zero
  function automatic digits_t bcd_dec(digits_t d);
    digits_t r;
    logic    borrow;
    r      = d;
    borrow = (d != '0);
    for (int k = 0; k < NumDigits; k++) begin
      if (borrow) begin
        if (d[k] != '0) begin
          r[k]   = d[k] - DigitW'(1);
          borrow = 1'b0;
        end else begin
          r[k] = DigitMax;
        end
      end
    end
    return r;
  endfunction

  // Step the value up by one, wrapping from 9999 to 0000
  function automatic digits_t bcd_inc(digits_t d);
    digits_t r;
    logic    carry;
    r     = d;
    carry = 1'b1;
    for (int k = 0; k < NumDigits; k++) begin
      if (carry) begin
        if (d[k] < DigitMax) begin
          r[k]  = d[k] + DigitW'(1);
          carry = 1'b0;
        end else begin
          r[k] = '0;
        end
      end
    end
    return r;
  endfunction

  // Seven-segment code, bit 0 is segment a; non-decimal codes go blank
  function automatic logic [SegW-1:0] seg_code(logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bcdt_regs.sv =====
// Configuration register file of the BCD countdown timer (APB-style port).
// Depends on bcdt_pkg.
`default_nettype none

module bcdt_regs
  import bcdt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready,
  output logic      [PrescW-1:0]   ticks_per_count_o
);

  logic [PrescW-1:0] tpc_q;
  logic              wr_en;
  logic              reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1];
  assign wr_en   = psel && penable && pwrite;

  // Write the prescaler reload at the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpc_q <= TicksPerCountRst;
    end else if (wr_en && (reg_idx == REG_TICKS_PER_COUNT)) begin
      tpc_q <= pwdata[PrescW-1:0];
    end
  end

  // Decode read data
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TICKS_PER_COUNT: prdata = ApbDataW'(tpc_q);
      default:             prdata = '0;
    endcase
  end

  assign ticks_per_count_o = tpc_q;

endmodule

`default_nettype wire

// ===== rtl/bcdt_step.sv =====
// Per-tick update logic of the BCD countdown timer: start, prescaled
// countdown, up, down, then buzzer. Depends on bcdt_pkg.
`default_nettype none

module bcdt_step
  import bcdt_pkg::*;
(
  input  wire timer_state_t      state_i,
  input  wire logic [PrescW-1:0] ticks_per_count_i,
  input  wire logic              start_i,
  input  wire logic              up_i,
  input  wire logic              down_i,
  output timer_state_t           state_o,
  output timer_result_t          result_o
);

  logic              run_start;
  logic [PrescW-1:0] presc_inc;
  logic              presc_hit;
  digits_t           dig_cnt;
  digits_t           dig_up;
  digits_t           dig_dn;

  // Start sets the running flag, then the prescaler advances
  assign run_start = state_i.running || start_i;
  assign presc_inc = state_i.prescale + PrescW'(1);
  assign presc_hit = run_start && (presc_inc == ticks_per_count_i);

  // Chain countdown, up and down on the digit value
  assign dig_cnt = presc_hit ? bcd_dec(state_i.digits) : state_i.digits;
  assign dig_up  = up_i ? bcd_inc(dig_cnt) : dig_cnt;
  assign dig_dn  = down_i ? bcd_dec(dig_up) : dig_up;

  always_comb begin
    state_o.running  = run_start && !up_i && !down_i;
    state_o.digits   = dig_dn;
    if (!run_start) begin
      state_o.prescale = state_i.prescale;
    end else if (presc_hit) begin
      state_o.prescale = '0;
    end else begin
      state_o.prescale = presc_inc;
    end
  end

  // Segments show the value before the update
  always_comb begin
    result_o.seg_thousands = seg_code(state_i.digits[3]);
    result_o.seg_hundreds  = seg_code(state_i.digits[2]);
    result_o.seg_tens      = seg_code(state_i.digits[1]);
    result_o.seg_units     = seg_code(state_i.digits[0]);
    result_o.is_running    = state_o.running;
    result_o.buzzer_on     = state_o.running && (dig_dn == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/bcd_countdown_timer_7seg.sv =====
// Top level of the 4-digit BCD countdown timer with seven-segment outputs.
// Depends on bcdt_pkg, bcdt_regs and bcdt_step.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o    | start/up/down_pressed_i
//   out     | out_valid_o / out_stall_i  | seg_*_o, buzzer_on_o, is_running_o
//   cfg     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One tick per cycle unless stalled: the timer state and the output register
// both load at the edge that takes the transaction, so the result is offered
// from the next cycle on. The input stalls only while a held result is stalled.
// Reset clears the running flag, prescaler and digits; reload resets to 50.
// No clearing pass after reset: the first tick is taken at once.
`default_nettype none

module bcd_countdown_timer_7seg
  import bcdt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                start_pressed_i,
  input  wire logic                up_pressed_i,
  input  wire logic                down_pressed_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [SegW-1:0]     seg_thousands_o,
  output logic      [SegW-1:0]     seg_hundreds_o,
  output logic      [SegW-1:0]     seg_tens_o,
  output logic      [SegW-1:0]     seg_units_o,
  output logic                     buzzer_on_o,
  output logic                     is_running_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  logic [PrescW-1:0] tpc;
  timer_state_t      state_q;
  timer_state_t      state_d;
  timer_result_t     result_d;
  timer_result_t     result_q;
  logic              out_valid_q;
  logic              in_accept;

  bcdt_regs u_regs (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .ticks_per_count_o (tpc)
  );

  bcdt_step u_step (
    .state_i           (state_q),
    .ticks_per_count_i (tpc),
    .start_i           (start_pressed_i),
    .up_i              (up_pressed_i),
    .down_i            (down_pressed_i),
    .state_o           (state_d),
    .result_o          (result_d)
  );

  // Take a transaction unless a held result is stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Advance timer state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // Hold the output valid until the result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign seg_thousands_o = result_q.seg_thousands;
  assign seg_hundreds_o  = result_q.seg_hundreds;
  assign seg_tens_o      = result_q.seg_tens;
  assign seg_units_o     = result_q.seg_units;
  assign buzzer_on_o     = result_q.buzzer_on;
  assign is_running_o    = result_q.is_running;

  // Digits always stay decimal
  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.digits[0] <= DigitMax) && (state_q.digits[1] <= DigitMax) &&
    (state_q.digits[2] <= DigitMax) && (state_q.digits[3] <= DigitMax))
    else $error("BCD digit out of range");

  // Timer state moves only on an accepted tick
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(state_q))
    else $error("timer state changed without a tick");

  // Buzzer needs the timer running
  a_buzzer_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buzzer_on_o |-> is_running_o)
    else $error("buzzer on while stopped");

  // Reported running flag matches the stored one after each tick
  a_running_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (is_running_o == state_q.running) && out_valid_o)
    else $error("running flag mismatch");

endmodule

`default_nettype wire
